### sv/dti_pkg.sv
// Shared types and constants for the damage table interpolator.
// No dependencies; used by damage_table_interpolator_core.
`timescale 1ns / 1ps

package dti_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH   = 64;
    localparam int STRAIN_BITS   = 32;
    localparam int DAMAGE_BITS   = 16;
    localparam int INDEX_BITS    = 7;
    localparam int LENGTH_BITS   = 7;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;

    // Entry numbers span 0..TABLE_DEPTH; entry 0 is the fixed zero pair
    localparam int ENTRY_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int DIV_CNT_W = $clog2(DAMAGE_BITS);

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRAIN_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_LENGTH     = 1'd1;

    // Commands
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    // Status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_ORDER = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic                   command;
        logic [INDEX_BITS-1:0]  entry_index;
        logic [STRAIN_BITS-1:0] jump_value;
        logic [DAMAGE_BITS-1:0] damage_value;
        logic [STRAIN_BITS-1:0] strain_kappa;
    } in_item_t;

    typedef struct packed {
        logic [DAMAGE_BITS-1:0] damage_out;
        status_t                status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_CHK,
        ST_Q_RDN,
        ST_Q_CHKN,
        ST_SR_RD,
        ST_SR_CMP,
        ST_SEG0_RD,
        ST_SEG0_CAP,
        ST_SEG1_CAP,
        ST_PREP,
        ST_DIV_A,
        ST_DIV_B,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

### sv/damage_table_interpolator_core.sv
// Damage table interpolator: breakpoint table, lower-bound search and
// serial interpolation divider under one sequencer.
// Depends on dti_pkg.
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_item  (dti_pkg::in_item_t)
// out     | output    | out_valid / out_ready| out_item (dti_pkg::out_item_t)
// cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One item at a time. A load reads the previous entry for the order check
// and writes when in order, but goes straight to the result when its
// index is out of range. A query at or below the threshold goes straight
// to the result, and one at or beyond the last breakpoint reads only that
// entry; otherwise a lower-bound search (1 to 7 probes over up to 65
// entries) and a read of both segment ends come first, then the divider
// unless kappa lands on a segment end. The table memory is single-port,
// and the 16-bit shift-subtract divider forms one quotient bit per pass.
// Reset (rst_n, async, low) clears the sequencer and the configuration
// registers; the table memory is not cleared. in_ready is high only while
// idle; a result holds on out_item until out_ready takes it.

module damage_table_interpolator_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  dti_pkg::in_item_t                      in_item,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output dti_pkg::out_item_t                     out_item,
    input  logic                                   cfg_we,
    input  logic [dti_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [dti_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int SW = dti_pkg::STRAIN_BITS;
    localparam int DW = dti_pkg::DAMAGE_BITS;
    localparam int EW = dti_pkg::ENTRY_W;
    localparam int AW = dti_pkg::ADDR_W;

    // Configuration
    logic [SW-1:0]                   thr_reg;
    logic [dti_pkg::LENGTH_BITS-1:0] len_reg;
    logic [EW-1:0]                   n_eff;

    // Sequencer
    dti_pkg::state_t state_reg, state_next;

    // Item and working registers (no reset)
    logic [EW-1:0]  idx_reg, idx_next;
    logic [SW-1:0]  jump_reg, jump_next;
    logic [DW-1:0]  dmg_reg, dmg_next;
    logic [SW-1:0]  kd_reg, kd_next;       // kappa minus threshold
    logic [EW-1:0]  first_reg, first_next;
    logic [EW-1:0]  count_reg, count_next;
    logic [SW-1:0]  bp0_reg, bp0_next;
    logic [SW-1:0]  bp1_reg, bp1_next;
    logic [DW-1:0]  y0_reg, y0_next;
    logic [DW-1:0]  y1_reg, y1_next;
    logic [SW-1:0]  a_reg, a_next;
    logic [SW-1:0]  b_reg, b_next;
    logic [SW-1:0]  r_reg, r_next;
    logic [DW-1:0]  q_reg, q_next;
    logic [DW-1:0]  m_reg, m_next;
    logic           neg_reg, neg_next;
    logic [dti_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  dout_reg, dout_next;
    dti_pkg::status_t status_reg, status_next;

    // Table memory, entries 1..TABLE_DEPTH at address entry-1
    logic [SW-1:0] bp_mem [dti_pkg::TABLE_DEPTH];
    logic [DW-1:0] dm_mem [dti_pkg::TABLE_DEPTH];
    logic          rd_en;
    logic [EW-1:0] rd_entry;
    logic          wr_en;
    logic [SW-1:0] rd_bp_reg;
    logic [DW-1:0] rd_dm_reg;
    logic          rd_zero_reg;
    logic [SW-1:0] rd_bp;
    logic [DW-1:0] rd_dm;

    // Combinational temporaries
    logic [EW-1:0] step;
    logic [EW-1:0] probe;
    logic [EW-1:0] seg;
    logic [SW:0]   r2;
    logic [SW:0]   sum;
    logic [SW:0]   b_ext;

    // Table length above depth saturates
    always_comb
    begin
        if (int'(len_reg) > dti_pkg::TABLE_DEPTH)
        begin
            n_eff = EW'(dti_pkg::TABLE_DEPTH);
        end
        else
        begin
            n_eff = EW'(len_reg);
        end
    end

    // Entry 0 is the fixed (0,0) pair
    assign rd_bp = rd_zero_reg ? '0 : rd_bp_reg;
    assign rd_dm = rd_zero_reg ? '0 : rd_dm_reg;

    assign in_ready  = (state_reg == dti_pkg::ST_IDLE);
    assign out_valid = (state_reg == dti_pkg::ST_OUT);
    assign out_item.damage_out = dout_reg;
    assign out_item.status     = status_reg;

    assign step  = count_reg >> 1;
    assign probe = first_reg + step;
    assign b_ext = {1'b0, b_reg};

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        jump_next   = jump_reg;
        dmg_next    = dmg_reg;
        kd_next     = kd_reg;
        first_next  = first_reg;
        count_next  = count_reg;
        bp0_next    = bp0_reg;
        bp1_next    = bp1_reg;
        y0_next     = y0_reg;
        y1_next     = y1_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        q_next      = q_reg;
        m_next      = m_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        dout_next   = dout_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_entry    = '0;
        wr_en       = 1'b0;
        seg         = first_reg;
        r2          = {r_reg, 1'b0};
        sum         = {1'b0, r_reg} + {1'b0, a_reg};

        case (state_reg)
            dti_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next    = EW'(in_item.entry_index);
                    jump_next   = in_item.jump_value;
                    dmg_next    = in_item.damage_value;
                    kd_next     = in_item.strain_kappa - thr_reg;
                    dout_next   = '0;
                    status_next = dti_pkg::STATUS_OK;
                    if (in_item.command == dti_pkg::CMD_LOAD)
                    begin
                        if (in_item.entry_index == '0 ||
                            int'(in_item.entry_index) > int'(n_eff))
                        begin
                            status_next = dti_pkg::STATUS_RANGE;
                            state_next  = dti_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = dti_pkg::ST_LD_RD;
                        end
                    end
                    else if (in_item.strain_kappa <= thr_reg)
                    begin
                        state_next = dti_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = dti_pkg::ST_Q_RDN;
                    end
                end
            end

            // Load: fetch the previous entry for the order check
            dti_pkg::ST_LD_RD:
            begin
                rd_en      = 1'b1;
                rd_entry   = idx_reg - EW'(1);
                state_next = dti_pkg::ST_LD_CHK;
            end

            dti_pkg::ST_LD_CHK:
            begin
                if (jump_reg < rd_bp || dmg_reg < rd_dm)
                begin
                    status_next = dti_pkg::STATUS_ORDER;
                end
                else
                begin
                    wr_en = 1'b1;
                end
                state_next = dti_pkg::ST_OUT;
            end

            // Query: saturate at or beyond the last breakpoint
            dti_pkg::ST_Q_RDN:
            begin
                rd_en      = 1'b1;
                rd_entry   = n_eff;
                state_next = dti_pkg::ST_Q_CHKN;
            end

            dti_pkg::ST_Q_CHKN:
            begin
                if (kd_reg >= rd_bp)
                begin
                    dout_next  = rd_dm;
                    state_next = dti_pkg::ST_OUT;
                end
                else
                begin
                    first_next = '0;
                    count_next = n_eff + EW'(1);
                    state_next = dti_pkg::ST_SR_RD;
                end
            end

            // Lower-bound search, one probe per pass through ST_SR_RD and ST_SR_CMP
            dti_pkg::ST_SR_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = dti_pkg::ST_SEG0_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_entry   = probe;
                    state_next = dti_pkg::ST_SR_CMP;
                end
            end

            dti_pkg::ST_SR_CMP:
            begin
                if (rd_bp < kd_reg)
                begin
                    first_next = probe + EW'(1);
                    count_next = count_reg - step - EW'(1);
                end
                else
                begin
                    count_next = step;
                end
                state_next = dti_pkg::ST_SR_RD;
            end

            // Clamp segment index to 1..N, read both ends
            dti_pkg::ST_SEG0_RD:
            begin
                if (first_reg == '0)
                begin
                    seg = EW'(1);
                end
                else if (first_reg > n_eff)
                begin
                    seg = n_eff;
                end
                idx_next   = seg;
                rd_en      = 1'b1;
                rd_entry   = seg - EW'(1);
                state_next = dti_pkg::ST_SEG0_CAP;
            end

            dti_pkg::ST_SEG0_CAP:
            begin
                bp0_next   = rd_bp;
                y0_next    = rd_dm;
                rd_en      = 1'b1;
                rd_entry   = idx_reg;
                state_next = dti_pkg::ST_SEG1_CAP;
            end

            dti_pkg::ST_SEG1_CAP:
            begin
                bp1_next   = rd_bp;
                y1_next    = rd_dm;
                state_next = dti_pkg::ST_PREP;
            end

            dti_pkg::ST_PREP:
            begin
                if (kd_reg <= bp0_reg)
                begin
                    dout_next  = y0_reg;
                    state_next = dti_pkg::ST_OUT;
                end
                else if (kd_reg >= bp1_reg)
                begin
                    dout_next  = y1_reg;
                    state_next = dti_pkg::ST_OUT;
                end
                else
                begin
                    a_next   = kd_reg - bp0_reg;
                    b_next   = bp1_reg - bp0_reg;
                    neg_next = (y1_reg < y0_reg);
                    m_next   = (y1_reg < y0_reg) ? (y0_reg - y1_reg) : (y1_reg - y0_reg);
                    r_next   = '0;
                    q_next   = '0;
                    cnt_next = dti_pkg::DIV_CNT_W'(DW - 1);
                    state_next = dti_pkg::ST_DIV_A;
                end
            end

            // floor(m*a/b): double remainder, then add a where m bit is set
            dti_pkg::ST_DIV_A:
            begin
                if (r2 >= b_ext)
                begin
                    r_next = SW'(r2 - b_ext);
                    q_next = {q_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    r_next = SW'(r2);
                    q_next = {q_reg[DW-2:0], 1'b0};
                end
                state_next = dti_pkg::ST_DIV_B;
            end

            dti_pkg::ST_DIV_B:
            begin
                if (m_reg[DW-1])
                begin
                    if (sum >= b_ext)
                    begin
                        r_next = SW'(sum - b_ext);
                        q_next = q_reg + DW'(1);
                    end
                    else
                    begin
                        r_next = SW'(sum);
                    end
                end
                m_next = m_reg << 1;
                if (cnt_reg == '0)
                begin
                    state_next = dti_pkg::ST_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg - dti_pkg::DIV_CNT_W'(1);
                    state_next = dti_pkg::ST_DIV_A;
                end
            end

            dti_pkg::ST_FIN:
            begin
                dout_next  = neg_reg ? (y0_reg - q_reg) : (y0_reg + q_reg);
                state_next = dti_pkg::ST_OUT;
            end

            dti_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = dti_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dti_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dti_pkg::ST_IDLE;
            thr_reg   <= '0;
            len_reg   <= dti_pkg::LENGTH_BITS'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dti_pkg::REG_STRAIN_THRESHOLD: thr_reg <= cfg_data[SW-1:0];
                    dti_pkg::REG_TABLE_LENGTH:     len_reg <= cfg_data[dti_pkg::LENGTH_BITS-1:0];
                    default:                       thr_reg <= thr_reg;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        jump_reg   <= jump_next;
        dmg_reg    <= dmg_next;
        kd_reg     <= kd_next;
        first_reg  <= first_next;
        count_reg  <= count_next;
        bp0_reg    <= bp0_next;
        bp1_reg    <= bp1_next;
        y0_reg     <= y0_next;
        y1_reg     <= y1_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        m_reg      <= m_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        dout_reg   <= dout_next;
        status_reg <= status_next;
    end

    // Table memory: one read or one write a cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bp_mem[AW'(idx_reg - EW'(1))] <= jump_reg;
            dm_mem[AW'(idx_reg - EW'(1))] <= dmg_reg;
        end
        if (rd_en)
        begin
            rd_bp_reg   <= bp_mem[AW'(rd_entry - EW'(1))];
            rd_dm_reg   <= dm_mem[AW'(rd_entry - EW'(1))];
            rd_zero_reg <= (rd_entry == '0);
        end
    end

    // Checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after an item was accepted");

    a_flag_zero_damage: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != dti_pkg::STATUS_OK) |-> (out_item.damage_out == '0))
        else $error("flagged load returned nonzero damage");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.status == dti_pkg::STATUS_OK ||
                       out_item.status == dti_pkg::STATUS_ORDER ||
                       out_item.status == dti_pkg::STATUS_RANGE))
        else $error("undefined status code");

endmodule
